// ----- hdl/block_log_fifo_cache_assert.svh -----
// ----------------------------------------------------------------------------
// Log FIFO cache assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BLOCK_LOG_FIFO_CACHE_ASSERT_SVH
`define BLOCK_LOG_FIFO_CACHE_ASSERT_SVH

// clocked assertion, off while reset is low
`define LFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, active during reset too
`define LFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/lfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Log FIFO cache package
// Result codes, register indexes, slot record and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfc_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned SizeW = 21;
  localparam int unsigned UsedW = 27;
  localparam int unsigned BiuW  = 7;

  localparam logic [SizeW-1:0] BlockBytesRst = SizeW'(65536);
  localparam logic [BiuW-1:0]  BlocksRst     = BiuW'(64);

  typedef enum logic [1:0] {
    CFG_BLOCK_BYTES = 2'd0,
    CFG_BLOCKS      = 2'd1,
    CFG_LAST_BYTES  = 2'd2
  } cfg_idx_e;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_FIND   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_EVICT = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FIND  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_TOO_BIG = 2'd1,
    STAT_DUP     = 2'd2
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [SizeW-1:0] bytes;
  } slot_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MRD,
    S_MCHK,
    S_SRD,
    S_SCHK,
    S_DEC,
    S_ACHK,
    S_NCHK,
    S_FRD,
    S_FEMIT,
    S_DONE
  } state_e;

endpackage

// ----- hdl/lfc_if.sv -----
// ----------------------------------------------------------------------------
// Log FIFO cache channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] key;
  logic [20:0] obj_bytes;

  modport source (output valid, command, key, obj_bytes, input ready);
  modport sink   (input valid, command, key, obj_bytes, output ready);
endinterface

interface lfc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] out_key;
  logic [20:0] out_bytes;
  logic        hit;
  logic [1:0]  status;
  logic [26:0] used_bytes;
  logic        last;

  modport source (output valid, kind, out_key, out_bytes, hit, status, used_bytes, last,
                  input ready);
  modport sink   (input valid, kind, out_key, out_bytes, hit, status, used_bytes, last,
                  output ready);
endinterface

// ----- hdl/lfc_ram.sv -----
// ----------------------------------------------------------------------------
// Log FIFO cache RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/block_log_fifo_cache.sv -----
// ----------------------------------------------------------------------------
// Log FIFO cache index
// Circular log of fixed-capacity blocks with flush-on-advance eviction.
// ----------------------------------------------------------------------------
// Requests arrive on in_i (insert or find) and results leave on out_o; each
// request yields one or more results, the final one flagged by last. The
// cfg_* port writes block_bytes, blocks_in_use and last_block_bytes; the
// user is to write them only while idle, as the block does not enforce it.
// One request at a time: every request first scans the block table and the
// slot memory until the key matches or all blocks are read. A new insert
// is stored in the active block if it fits; else an oversize item is
// rejected, or the next block is flushed, each evicted item emitted, and
// the item stored there. After reset the block table is zeroed, one block a
// cycle, before the first request is taken. A stalled receiver holds the
// result register, and the sequencer waits until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_log_fifo_cache #(
  parameter int unsigned MAX_BLOCKS      = 64,
  parameter int unsigned SLOTS_PER_BLOCK = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  lfc_pkg::cfg_idx_e     cfg_addr_i,
  input  logic [20:0]           cfg_wdata_i,
  lfc_in_if.sink                in_i,
  lfc_out_if.source             out_o
);

  import lfc_pkg::*;

  localparam int unsigned BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW  = $clog2(SLOTS_PER_BLOCK + 1);
  localparam int unsigned Depth = MAX_BLOCKS * SLOTS_PER_BLOCK;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RW    = ($clog2(MAX_BLOCKS + 1) > BiuW) ?
                                  $clog2(MAX_BLOCKS + 1) : BiuW;

  typedef struct packed {
    logic [SizeW-1:0] fill;
    logic [CntW-1:0]  cnt;
  } meta_t;

  state_e state_q, state_d;

  logic [SizeW-1:0] blk_bytes_q, last_bytes_q;
  logic [BiuW-1:0]  blocks_q;

  logic [BW-1:0]    clr_q, clr_d, blk_q, blk_d, active_q, active_d, tgt_q, tgt_d;
  logic [AW-1:0]    base_q, base_d;
  logic [CntW-1:0]  slot_q, slot_d, cnt_q, cnt_d;
  logic             found_q, found_d, flush_q, flush_d;
  logic             cmd_q;
  logic [KeyW-1:0]  key_q;
  logic [SizeW-1:0] size_q, fill_q, fill_d;
  logic [UsedW-1:0] total_q, total_d;

  logic             ov_q;
  logic [1:0]       okind_q;
  logic [KeyW-1:0]  okey_q;
  logic [SizeW-1:0] obytes_q;
  logic             ohit_q;
  logic [1:0]       ostat_q;
  logic [UsedW-1:0] oused_q;
  logic             olast_q;

  logic             emit, emit_ok, e_hit, e_last;
  kind_e            e_kind;
  status_e          e_stat;
  logic [KeyW-1:0]  e_key;
  logic [SizeW-1:0] e_bytes;
  logic [UsedW-1:0] e_used;

  logic             m_we, m_re, s_we, s_re;
  logic [BW-1:0]    m_waddr, m_raddr;
  meta_t            m_wdata, m_rdata;
  logic [AW-1:0]    s_waddr, s_raddr;
  slot_t            s_wdata, s_rdata;

  logic [RW-1:0]    ring;
  logic [BW-1:0]    nx;
  logic [SizeW-1:0] cap_act, cap_nx;
  logic             fits;
  logic [SizeW:0]   fill_sum;
  logic [AW-1:0]    tgt_base;

  always_comb begin
    if (blocks_q == '0) begin
      ring = RW'(1);
    end else if (RW'(blocks_q) > RW'(MAX_BLOCKS)) begin
      ring = RW'(MAX_BLOCKS);
    end else begin
      ring = RW'(blocks_q);
    end
    nx = (RW'(active_q) + RW'(1) >= ring) ? '0 : active_q + BW'(1);
    cap_act = (RW'(active_q) == ring - RW'(1) && last_bytes_q != '0) ?
              last_bytes_q : blk_bytes_q;
    cap_nx  = (RW'(nx) == ring - RW'(1) && last_bytes_q != '0) ?
              last_bytes_q : blk_bytes_q;
    fill_sum = {1'b0, m_rdata.fill} + {1'b0, size_q};
    fits = (m_rdata.cnt < CntW'(SLOTS_PER_BLOCK)) && (fill_sum <= {1'b0, cap_act});
    tgt_base = AW'(AW'(tgt_q) * AW'(SLOTS_PER_BLOCK));
  end

  assign emit_ok = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    blk_d    = blk_q;
    base_d   = base_q;
    slot_d   = slot_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    flush_d  = flush_q;
    active_d = active_q;
    tgt_d    = tgt_q;
    fill_d   = fill_q;
    total_d  = total_q;
    emit     = 1'b0;
    e_kind   = KIND_DONE;
    e_stat   = STAT_OK;
    e_key    = key_q;
    e_bytes  = '0;
    e_hit    = 1'b0;
    e_last   = 1'b1;
    e_used   = total_q;
    m_we     = 1'b0;
    m_waddr  = tgt_q;
    m_wdata  = '0;
    m_re     = 1'b0;
    m_raddr  = blk_q;
    s_we     = 1'b0;
    s_waddr  = tgt_base + (flush_q ? AW'(0) : AW'(cnt_q));
    s_wdata  = '{key: key_q, bytes: size_q};
    s_re     = 1'b0;
    s_raddr  = base_q + AW'(slot_q);

    unique case (state_q)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        clr_d   = clr_q + BW'(1);
        if (clr_q == BW'(MAX_BLOCKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          blk_d   = '0;
          base_d  = '0;
          found_d = 1'b0;
          state_d = S_MRD;
        end
      end
      S_MRD: begin
        m_re    = 1'b1;
        state_d = S_MCHK;
      end
      S_MCHK: begin
        cnt_d  = m_rdata.cnt;
        slot_d = '0;
        if (m_rdata.cnt != '0) begin
          state_d = S_SRD;
        end else if (blk_q == BW'(MAX_BLOCKS - 1)) begin
          state_d = S_DEC;
        end else begin
          blk_d   = blk_q + BW'(1);
          base_d  = base_q + AW'(SLOTS_PER_BLOCK);
          state_d = S_MRD;
        end
      end
      S_SRD: begin
        s_re    = 1'b1;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        slot_d = slot_q + CntW'(1);
        if (s_rdata.key == key_q) begin
          found_d = 1'b1;
          state_d = S_DEC;
        end else if (slot_q + CntW'(1) != cnt_q) begin
          state_d = S_SRD;
        end else if (blk_q == BW'(MAX_BLOCKS - 1)) begin
          state_d = S_DEC;
        end else begin
          blk_d   = blk_q + BW'(1);
          base_d  = base_q + AW'(SLOTS_PER_BLOCK);
          state_d = S_MRD;
        end
      end
      S_DEC: begin
        priority if (cmd_q == CMD_FIND) begin
          e_kind = KIND_FIND;
          e_hit  = found_q;
          if (emit_ok) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else if (found_q) begin
          e_stat = STAT_DUP;
          if (emit_ok) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          m_re    = 1'b1;
          m_raddr = active_q;
          state_d = S_ACHK;
        end
      end
      S_ACHK: begin
        priority if (fits) begin
          tgt_d   = active_q;
          fill_d  = fill_sum[SizeW-1:0];
          cnt_d   = m_rdata.cnt;
          flush_d = 1'b0;
          total_d = total_q + UsedW'(size_q);
          state_d = S_DONE;
        end else if (size_q > cap_nx) begin
          e_stat = STAT_TOO_BIG;
          if (emit_ok) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          m_re    = 1'b1;
          m_raddr = nx;
          tgt_d   = nx;
          state_d = S_NCHK;
        end
      end
      S_NCHK: begin
        cnt_d   = m_rdata.cnt;
        slot_d  = '0;
        fill_d  = size_q;
        flush_d = 1'b1;
        total_d = total_q - UsedW'(m_rdata.fill) + UsedW'(size_q);
        state_d = (m_rdata.cnt == '0) ? S_DONE : S_FRD;
      end
      S_FRD: begin
        s_re    = 1'b1;
        s_raddr = tgt_base + AW'(slot_q);
        state_d = S_FEMIT;
      end
      S_FEMIT: begin
        e_kind  = KIND_EVICT;
        e_key   = s_rdata.key;
        e_bytes = s_rdata.bytes;
        e_last  = 1'b0;
        if (emit_ok) begin
          emit    = 1'b1;
          slot_d  = slot_q + CntW'(1);
          state_d = (slot_q + CntW'(1) == cnt_q) ? S_DONE : S_FRD;
        end
      end
      S_DONE: begin
        if (emit_ok) begin
          emit     = 1'b1;
          m_we     = 1'b1;
          m_wdata  = '{fill: fill_q, cnt: flush_q ? CntW'(1) : cnt_q + CntW'(1)};
          s_we     = 1'b1;
          active_d = tgt_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  lfc_ram #(.WIDTH($bits(meta_t)), .DEPTH(MAX_BLOCKS)) u_meta_ram (
    .clk_i,
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  lfc_ram #(.WIDTH($bits(slot_t)), .DEPTH(Depth)) u_slot_ram (
    .clk_i,
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      blk_q        <= '0;
      base_q       <= '0;
      slot_q       <= '0;
      cnt_q        <= '0;
      found_q      <= 1'b0;
      flush_q      <= 1'b0;
      active_q     <= '0;
      tgt_q        <= '0;
      total_q      <= '0;
      ov_q         <= 1'b0;
      blk_bytes_q  <= BlockBytesRst;
      blocks_q     <= BlocksRst;
      last_bytes_q <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      blk_q    <= blk_d;
      base_q   <= base_d;
      slot_q   <= slot_d;
      cnt_q    <= cnt_d;
      found_q  <= found_d;
      flush_q  <= flush_d;
      active_q <= active_d;
      tgt_q    <= tgt_d;
      total_q  <= total_d;
      ov_q     <= emit ? 1'b1 : (out_o.ready ? 1'b0 : ov_q);
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_BLOCK_BYTES: blk_bytes_q  <= cfg_wdata_i;
          CFG_BLOCKS:      blocks_q     <= cfg_wdata_i[BiuW-1:0];
          CFG_LAST_BYTES:  last_bytes_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q  <= in_i.command;
      key_q  <= in_i.key;
      size_q <= in_i.obj_bytes;
    end
    fill_q <= fill_d;
    if (emit) begin
      okind_q  <= e_kind;
      okey_q   <= e_key;
      obytes_q <= e_bytes;
      ohit_q   <= e_hit;
      ostat_q  <= e_stat;
      oused_q  <= e_used;
      olast_q  <= e_last;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.kind       = okind_q;
  assign out_o.out_key    = okey_q;
  assign out_o.out_bytes  = obytes_q;
  assign out_o.hit        = ohit_q;
  assign out_o.status     = ostat_q;
  assign out_o.used_bytes = oused_q;
  assign out_o.last       = olast_q;

endmodule

// ----- hdl/lfc_checker.sv -----
// ----------------------------------------------------------------------------
// Log FIFO cache checker
// Port-level assertions on request and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_log_fifo_cache_assert.svh"

module lfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [31:0] out_key_i,
  input logic [20:0] out_bytes_i,
  input logic        out_hit_i,
  input logic [1:0]  out_status_i,
  input logic [26:0] out_used_i,
  input logic        out_last_i
);

  import lfc_pkg::*;

  `LFC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_key_i) && $stable(out_kind_i) && $stable(out_used_i) && $stable(out_last_i), "result changed while stalled")
  `LFC_ASSERT(a_one_at_a_time, in_valid_i && in_ready_i |=> !in_ready_i, "request taken while busy")
  `LFC_ASSERT(a_busy_mid_step, out_valid_i && !out_last_i |-> !in_ready_i, "ready before step ends")
  `LFC_ASSERT(a_fields_clean, out_valid_i && out_kind_i != KIND_EVICT |-> out_bytes_i == '0 && (out_hit_i == 1'b0 || out_kind_i == KIND_FIND) && (out_status_i == STAT_OK || out_kind_i == KIND_DONE), "result fields inconsistent with kind")

endmodule

bind block_log_fifo_cache lfc_checker u_lfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_kind_i   (out_o.kind),
  .out_key_i    (out_o.out_key),
  .out_bytes_i  (out_o.out_bytes),
  .out_hit_i    (out_o.hit),
  .out_status_i (out_o.status),
  .out_used_i   (out_o.used_bytes),
  .out_last_i   (out_o.last)
);

// ----- tb/tb_block_log_fifo_cache.sv -----
// ----------------------------------------------------------------------------
// Log FIFO cache testbench
// Drives inserts and finds through the request channel under random idling,
// predicts every result from its own copy of the log and checks each field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_block_log_fifo_cache;
  import lfc_pkg::*;

  localparam int unsigned NBLK   = 64;
  localparam int unsigned NSLOT  = 32;
  localparam int unsigned LIMIT  = 3000000;

  typedef struct packed {
    cmd_e              command;
    logic [31:0]       key;
    logic [20:0]       obj_bytes;
  } req_t;

  typedef struct packed {
    kind_e             kind;
    logic [31:0]       out_key;
    logic [20:0]       out_bytes;
    logic              hit;
    status_e           status;
    logic [26:0]       used_bytes;
    logic              last;
  } res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cfg_idx_e cfg_addr_i;
  logic [20:0] cfg_wdata_i;

  lfc_in_if  req_ch ();
  lfc_out_if res_ch ();

  block_log_fifo_cache u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (req_ch.sink),
    .out_o      (res_ch.source)
  );

  req_t pending_reqs[$];
  res_t expected_results[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_cycles;
  int unsigned errors;
  int unsigned cycle_cnt;
  int unsigned n_sent;
  int unsigned n_evict;
  int unsigned n_hits;
  int unsigned n_big;
  int unsigned n_dup;

  // Predictor state
  logic [20:0] cap_bytes;
  logic [6:0]  ring_reg;
  logic [20:0] last_bytes;
  logic [5:0]  active_blk;
  logic [26:0] log_used;
  logic [20:0] blk_fill[NBLK];
  logic [5:0]  blk_count[NBLK];
  logic [31:0] slot_keys[NBLK][NSLOT];
  logic [20:0] slot_sizes[NBLK][NSLOT];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned ring_len();
    if (ring_reg == 0) return 1;
    if (ring_reg > NBLK) return NBLK;
    return ring_reg;
  endfunction

  function automatic int unsigned blk_cap(int unsigned b);
    if (b == ring_len() - 1 && last_bytes != 0) return last_bytes;
    return cap_bytes;
  endfunction

  function automatic bit key_held(logic [31:0] k);
    for (int b = 0; b < NBLK; b++)
      for (int s = 0; s < blk_count[b]; s++)
        if (slot_keys[b][s] == k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void set_reg(cfg_idx_e idx, logic [20:0] val);
    case (idx)
      CFG_BLOCK_BYTES: cap_bytes = val;
      CFG_BLOCKS:      ring_reg = val[6:0];
      default:         last_bytes = val;
    endcase
  endfunction

  task automatic predict_log_step(req_t r);
    res_t  step[$];
    res_t  one;
    int unsigned b;
    int unsigned nx;
    status_e st;
    b = active_blk;
    st = STAT_OK;
    one = '0;
    one.out_key = r.key;
    if (r.command == CMD_FIND) begin
      one.kind = KIND_FIND;
      one.hit = key_held(r.key);
      if (one.hit) n_hits++;
      step = {step, one};
    end else if (key_held(r.key)) begin
      one.kind = KIND_DONE;
      one.status = STAT_DUP;
      n_dup++;
      step = {step, one};
    end else begin
      if (blk_count[b] >= NSLOT || 64'(blk_fill[b]) + r.obj_bytes > 64'(blk_cap(b))) begin
        nx = b + 1;
        if (nx >= ring_len()) nx = 0;
        if (r.obj_bytes > blk_cap(nx)) begin
          st = STAT_TOO_BIG;
          n_big++;
        end else begin
          for (int s = 0; s < blk_count[nx]; s++) begin
            res_t ev;
            ev = '0;
            ev.kind = KIND_EVICT;
            ev.out_key = slot_keys[nx][s];
            ev.out_bytes = slot_sizes[nx][s];
            step = {step, ev};
            n_evict++;
          end
          log_used = log_used - 27'(blk_fill[nx]);
          blk_fill[nx] = '0;
          blk_count[nx] = '0;
          active_blk = nx[5:0];
          b = nx;
        end
      end
      if (st == STAT_OK) begin
        slot_keys[b][blk_count[b]] = r.key;
        slot_sizes[b][blk_count[b]] = r.obj_bytes;
        blk_count[b] = blk_count[b] + 1;
        blk_fill[b] = blk_fill[b] + r.obj_bytes;
        log_used = log_used + 27'(r.obj_bytes);
      end
      one.kind = KIND_DONE;
      one.status = st;
      step = {step, one};
    end
    foreach (step[i]) begin
      step[i].used_bytes = log_used;
      step[i].last = (i == step.size() - 1);
      expected_results = {expected_results, step[i]};
    end
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_log_step(req_t'({req_ch.command, req_ch.key, req_ch.obj_bytes}));
        n_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_t r;
          r = pending_reqs.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.command   <= r.command;
          req_ch.key       <= r.key;
          req_ch.obj_bytes <= r.obj_bytes;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer key=%h", res_ch.out_key);
          errors++;
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (res_ch.kind != e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, res_ch.kind); errors++;
          end
          if (res_ch.out_key != e.out_key) begin
            $error("out_key: expected %h actual %h", e.out_key, res_ch.out_key); errors++;
          end
          if (res_ch.out_bytes != e.out_bytes) begin
            $error("out_bytes: expected %0d actual %0d", e.out_bytes, res_ch.out_bytes);
            errors++;
          end
          if (res_ch.hit != e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, res_ch.hit); errors++;
          end
          if (res_ch.status != e.status) begin
            $error("status: expected %0d actual %0d", e.status, res_ch.status); errors++;
          end
          if (res_ch.used_bytes != e.used_bytes) begin
            $error("used_bytes: expected %0d actual %0d", e.used_bytes, res_ch.used_bytes);
            errors++;
          end
          if (res_ch.last != e.last) begin
            $error("last: expected %0d actual %0d", e.last, res_ch.last); errors++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  logic [31:0] used_keys[$];

  function automatic logic [31:0] fresh_key();
    logic [31:0] k;
    k = $urandom();
    used_keys = {used_keys, k};
    return k;
  endfunction

  function automatic logic [31:0] old_key();
    if (used_keys.size() == 0) return $urandom();
    return used_keys[$urandom_range(used_keys.size() - 1)];
  endfunction

  task automatic add_req(cmd_e c, logic [31:0] k, logic [20:0] sz);
    pending_reqs = {pending_reqs, req_t'({c, k, sz})};
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (pending_reqs.size() > 0 || req_ch.valid || expected_results.size() > 0)
      @(negedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [20:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n, int unsigned max_sz);
    repeat (n) begin
      int unsigned p;
      logic [20:0] sz;
      p = $urandom_range(99);
      sz = (p % 7 == 0) ? 21'($urandom()) : 21'($urandom_range(max_sz));
      if (p < 50)      add_req(CMD_INSERT, fresh_key(), sz);
      else if (p < 60) add_req(CMD_INSERT, old_key(), sz);
      else if (p < 85) add_req(CMD_FIND, old_key(), '0);
      else             add_req(CMD_FIND, $urandom(), '0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = CFG_BLOCK_BYTES;
    cfg_wdata_i = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_INSERT;
    req_ch.key = '0;
    req_ch.obj_bytes = '0;
    res_ch.ready = 1'b0;
    errors = 0; n_sent = 0; n_evict = 0; n_hits = 0; n_big = 0; n_dup = 0;
    hold_off_cycles = 0;
    send_idle_pct = 10;
    recv_idle_pct = 73;
    cap_bytes = BlockBytesRst;
    ring_reg = BlocksRst;
    last_bytes = '0;
    active_blk = '0;
    log_used = '0;
    for (int b = 0; b < NBLK; b++) begin
      blk_fill[b] = '0;
      blk_count[b] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: defaults, then a tiny ring with a short last block
    add_req(CMD_FIND, 32'h0, '0);
    add_req(CMD_INSERT, 32'h0, 21'd0);
    add_req(CMD_INSERT, 32'hFFFF_FFFF, 21'd65536);
    add_req(CMD_INSERT, 32'hFFFF_FFFF, 21'd1);
    add_req(CMD_FIND, 32'hFFFF_FFFF, '0);
    add_req(CMD_INSERT, 32'h1234_5678, 21'h1F_FFFF);
    add_req(CMD_INSERT, 32'h1, 21'd65536);
    drain();
    write_reg(CFG_BLOCK_BYTES, 21'd100);
    write_reg(CFG_BLOCKS, 7'd3);
    write_reg(CFG_LAST_BYTES, 21'd40);
    for (int i = 0; i < 33; i++) add_req(CMD_INSERT, fresh_key(), 21'd1);
    add_req(CMD_INSERT, fresh_key(), 21'd99);
    add_req(CMD_INSERT, fresh_key(), 21'd60);
    add_req(CMD_INSERT, fresh_key(), 21'd90);
    add_req(CMD_FIND, old_key(), '0);
    drain();

    // Random, phase 1
    write_reg(CFG_BLOCK_BYTES, 21'd200);
    write_reg(CFG_BLOCKS, 7'd0);
    write_reg(CFG_LAST_BYTES, 21'd0);
    random_phase(40, 60);
    drain();
    write_reg(CFG_BLOCKS, 7'd127);
    write_reg(CFG_BLOCK_BYTES, 21'd1);
    random_phase(30, 2);
    drain();

    // Swap idling; hold off receiver so the block stalls its input
    send_idle_pct = 73;
    recv_idle_pct = 10;
    write_reg(CFG_BLOCK_BYTES, 21'd300);
    write_reg(CFG_BLOCKS, 7'd4);
    write_reg(CFG_LAST_BYTES, 21'h1F_FFFF);
    hold_off_cycles = 3000;
    random_phase(60, 150);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_BLOCK_BYTES, 21'h10_0000);
    write_reg(CFG_BLOCKS, 7'd2);
    write_reg(CFG_LAST_BYTES, 21'd1);
    random_phase(40, 400);
    drain();
    write_reg(CFG_BLOCKS, 7'd64);
    write_reg(CFG_BLOCK_BYTES, 21'd500);
    random_phase(40, 200);
    drain();

    $display("Sent %0d requests: %0d evictions, %0d find hits, %0d oversize, %0d duplicates.",
             n_sent, n_evict, n_hits, n_big, n_dup);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/lfc_pkg.sv
hdl/lfc_if.sv
hdl/lfc_ram.sv
hdl/block_log_fifo_cache.sv
hdl/lfc_checker.sv
tb/tb_block_log_fifo_cache.sv
